/* src/string_to_signed_integer_parser_macros.svh */
// Assertion helpers used by the checker of the parser.
`ifndef STRING_TO_SIGNED_INTEGER_PARSER_MACROS_SVH
`define STRING_TO_SIGNED_INTEGER_PARSER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STOI_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define STOI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* src/stoi_pkg.sv */
`timescale 1ns / 1ps

package stoi_pkg;

  localparam int OFFSET_BITS = 16;
  localparam int RADIX_BITS  = 6;
  localparam int PROD_BITS   = 64 + RADIX_BITS;

  localparam logic [RADIX_BITS-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_BITS-1:0] RADIX_ONE   = 6'd1;
  localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 6'd36;

  localparam logic [7:0] CH_0       = 8'd48;
  localparam logic [7:0] CH_9       = 8'd57;
  localparam logic [7:0] CH_UPPER_A = 8'd65;
  localparam logic [7:0] CH_UPPER_Z = 8'd90;
  localparam logic [7:0] CH_LOWER_A = 8'd97;
  localparam logic [7:0] CH_LOWER_Z = 8'd122;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] CH_PLUS    = 8'd43;
  localparam logic [7:0] CH_MINUS   = 8'd45;
  localparam logic [7:0] CASE_GAP   = 8'd32;
  localparam logic [7:0] LETTER_BIAS = 8'd10;
  localparam logic [6:0] DIGIT_NONE = 7'd99;

  localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_RANGE   = 2'd1;
  localparam logic [1:0] STAT_BADBASE = 2'd2;

  typedef enum logic [1:0] {
    SEL_ZERO  = 2'd0,
    SEL_ACC   = 2'd1,
    SEL_LIMIT = 2'd2,
    SEL_BAD   = 2'd3
  } emit_sel_t;

  typedef struct packed {
    logic      clear;
    logic      bump;
    logic      set_sign;
    logic      mul;
    logic      commit;
    logic      emit;
    emit_sel_t sel;
  } stoi_cmd_t;

  typedef struct packed {
    logic start;
    logic space;
    logic sign;
    logic digit_ok;
    logic radix_bad;
    logic ovf;
  } stoi_sts_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic [6:0] digit_of(input logic [7:0] c);
    logic [7:0] u;
    u = (c >= CH_LOWER_A && c <= CH_LOWER_Z) ? c - CASE_GAP : c;
    if (u >= CH_0 && u <= CH_9) begin
      return 7'(u - CH_0);
    end else if (u >= CH_UPPER_A && u <= CH_UPPER_Z) begin
      return 7'(u - CH_UPPER_A + LETTER_BIAS);
    end else begin
      return DIGIT_NONE;
    end
  endfunction

endpackage

/* src/stoi_dp.sv */
`timescale 1ns / 1ps

module stoi_dp
  import stoi_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [RADIX_BITS-1:0]  cfg_data,
  input  logic [7:0]             ch,
  input  logic                   start_req,
  input  stoi_cmd_t              cmd,
  output stoi_sts_t              sts,
  output logic signed [63:0]     value,
  output logic [1:0]             status,
  output logic [15:0]            end_offset
);

  logic [RADIX_BITS-1:0]  radix;
  logic [RADIX_BITS-1:0]  base;
  logic [63:0]            acc;
  logic                   negative;
  logic [OFFSET_BITS-1:0] position;
  logic [PROD_BITS-1:0]   prod;
  logic [RADIX_BITS-1:0]  digit;

  logic [RADIX_BITS-1:0]  radix_eff;
  logic [RADIX_BITS-1:0]  base_eff;
  logic [63:0]            acc_eff;
  logic [6:0]             d;
  logic [PROD_BITS-1:0]   prod_next;
  logic [PROD_BITS-1:0]   sum;
  logic [63:0]            limit;
  logic [OFFSET_BITS-1:0] pos_base;
  logic [OFFSET_BITS-1:0] position_next;
  logic [OFFSET_BITS+15:0] pos_wide;
  logic [63:0]            value_next;

  assign radix_eff = (radix == '0) ? RADIX_RESET : radix;
  assign base_eff  = start_req ? radix_eff : base;
  assign acc_eff   = start_req ? 64'd0 : acc;
  assign d         = digit_of(ch);
  assign prod_next = {{RADIX_BITS{1'b0}}, acc_eff} * {64'd0, base_eff};

  assign sum   = prod + {64'd0, digit};
  assign limit = negative ? NEG_LIMIT : POS_LIMIT;

  assign sts.start     = start_req;
  assign sts.space     = is_space(ch);
  assign sts.sign      = (ch == CH_PLUS) || (ch == CH_MINUS);
  assign sts.digit_ok  = d < {1'b0, base_eff};
  assign sts.radix_bad = (radix == RADIX_ONE) || (radix > RADIX_MAX);
  assign sts.ovf       = sum > {{RADIX_BITS{1'b0}}, limit};

  // Saturate the offset; clear and bump can land in the same cycle.
  always_comb begin
    pos_base      = cmd.clear ? '0 : position;
    position_next = pos_base;
    if (cmd.bump && pos_base != '1) begin
      position_next = pos_base + 1'b1;
    end
  end

  assign pos_wide = {16'd0, position};

  always_comb begin
    unique case (cmd.sel)
      SEL_ACC:   value_next = negative ? 64'd0 - acc : acc;
      SEL_LIMIT: value_next = limit;
      default:   value_next = 64'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_we) begin
      radix <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    position <= position_next;
    if (cmd.clear) begin
      base <= radix_eff;
      acc  <= 64'd0;
    end
    if (cmd.set_sign) begin
      negative <= (ch == CH_MINUS);
    end else if (cmd.clear) begin
      negative <= 1'b0;
    end
    if (cmd.mul) begin
      prod  <= prod_next;
      digit <= d[RADIX_BITS-1:0];
    end
    if (cmd.commit) begin
      acc <= sum[63:0];
    end
    if (cmd.emit) begin
      value <= value_next;
      unique case (cmd.sel)
        SEL_LIMIT: status <= STAT_RANGE;
        SEL_BAD:   status <= STAT_BADBASE;
        default:   status <= STAT_OK;
      endcase
      if (cmd.sel == SEL_ACC || cmd.sel == SEL_LIMIT) begin
        end_offset <= pos_wide[15:0];
      end else begin
        end_offset <= 16'd0;
      end
    end
  end

endmodule

/* src/stoi_ctrl.sv */
`timescale 1ns / 1ps

module stoi_ctrl
  import stoi_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  stoi_sts_t sts,
  output stoi_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_DONE = 5'b00001,
    S_LEAD = 5'b00010,
    S_SIGN = 5'b00100,
    S_DIGS = 5'b01000,
    S_CALC = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  state_t phase_eff;
  logic   out_valid_next;
  logic   accept;
  logic   take_digit;

  assign in_stall  = (state == S_CALC) || (out_valid && out_stall);
  assign accept    = in_valid && !in_stall;
  assign phase_eff = sts.start ? S_LEAD : state;

  always_comb begin
    cmd            = '0;
    cmd.sel        = SEL_ZERO;
    state_next     = state;
    out_valid_next = out_valid && out_stall;
    take_digit     = 1'b0;

    if (state == S_CALC) begin
      if (sts.ovf) begin
        cmd.emit       = 1'b1;
        cmd.sel        = SEL_LIMIT;
        out_valid_next = 1'b1;
        state_next     = S_DONE;
      end else begin
        cmd.commit = 1'b1;
        cmd.bump   = 1'b1;
        state_next = S_DIGS;
      end
    end else if (accept) begin
      cmd.clear  = sts.start;
      state_next = phase_eff;
      if (sts.start && sts.radix_bad) begin
        cmd.emit       = 1'b1;
        cmd.sel        = SEL_BAD;
        out_valid_next = 1'b1;
        state_next     = S_DONE;
      end else begin
        unique case (phase_eff) inside
          S_LEAD: begin
            if (sts.space) begin
              cmd.bump = 1'b1;
            end else if (sts.sign) begin
              cmd.set_sign = 1'b1;
              cmd.bump     = 1'b1;
              state_next   = S_SIGN;
            end else begin
              take_digit = 1'b1;
            end
          end
          S_SIGN, S_DIGS: begin
            take_digit = 1'b1;
          end
          default: begin
          end
        endcase
        if (take_digit) begin
          if (sts.digit_ok) begin
            cmd.mul    = 1'b1;
            state_next = S_CALC;
          end else begin
            cmd.emit       = 1'b1;
            cmd.sel        = (phase_eff == S_DIGS) ? SEL_ACC : SEL_ZERO;
            out_valid_next = 1'b1;
            state_next     = S_DONE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_DONE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* src/string_to_signed_integer_parser.sv */
`timescale 1ns / 1ps
// A result is valid the cycle after the word that ends conversion, or, for a
// digit word that overflows, after its range compare in S_CALC.
// A digit word takes a 64x6 multiply, then add and range compare in S_CALC,
// with input stalled meanwhile; whitespace, sign and ignored words need neither.
// Reset (rst, synchronous): radix back to ten, no string in progress, no result.
module string_to_signed_integer_parser
  import stoi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            ch,
  input  logic                  start_req,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [63:0]    value,
  output logic [1:0]            status,
  output logic [15:0]           end_offset,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [RADIX_BITS-1:0] cfg_data
);

  stoi_cmd_t cmd;
  stoi_sts_t sts;

  assign cfg_ready = 1'b1;

  stoi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  stoi_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .ch         (ch),
    .start_req  (start_req),
    .cmd        (cmd),
    .sts        (sts),
    .value      (value),
    .status     (status),
    .end_offset (end_offset)
  );

endmodule

/* src/stoi_checker.sv */
`timescale 1ns / 1ps
`include "string_to_signed_integer_parser_macros.svh"

module stoi_checker
  import stoi_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic [7:0]         ch,
  input logic               start_req,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [63:0] value,
  input logic [1:0]         status,
  input logic [15:0]        end_offset
);

  logic [81:0] out_word;
  logic        zero_word;
  logic        sat_value;
  logic        nul_start;

  assign out_word  = {value, status, end_offset};
  assign zero_word = (value == 64'd0) && (end_offset == 16'd0);
  assign sat_value = (value == POS_LIMIT) || (value == NEG_LIMIT);
  assign nul_start = in_valid && !in_stall && start_req && (ch == 8'd0);

  // A held result keeps its word.
  `STOI_ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_word))

  // Bad base reports nothing converted.
  `STOI_ASSERT_NOW(a_badbase, clk, rst, out_valid && status == STAT_BADBASE, zero_word)

  // Range errors carry a saturated value.
  `STOI_ASSERT_NOW(a_range, clk, rst, out_valid && status == STAT_RANGE, sat_value)

  // A string that opens with NUL ends at once with zero.
  `STOI_ASSERT_NEXT(a_nul, clk, rst, nul_start, out_valid && zero_word)

endmodule

bind string_to_signed_integer_parser stoi_checker u_stoi_checker (.*);
